// File: design/swarp_pkg.sv
// swarp_pkg: shared types, codes and constants of the sine warp block
// includes the quarter-wave sine entry function used to build the rom
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package swarp_pkg;

  localparam int SINE_DEPTH = 1024;
  localparam int SINE_AW = $clog2(SINE_DEPTH);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BAND_FOR_X   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BAND_FOR_Y   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_FACTOR = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISP_GAIN    = 3'd6;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_BAND   = 2'd1;
  localparam logic [1:0] MODE_RENDER = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  x_pos;
    logic [8:0]  y_pos;
    logic [23:0] pixel_color;
    logic [5:0]  band_index;
    logic [15:0] band_magnitude;
  } item_t;

  typedef struct packed {
    logic [23:0] warped_color;
    logic [8:0]  source_x;
    logic [8:0]  source_y;
  } result_t;

  // decoded configuration as seen by the datapath
  typedef struct packed {
    logic [9:0]  act_w;
    logic [9:0]  act_h;
    logic [5:0]  band_x;
    logic [5:0]  band_y;
    logic        band_x_ok;
    logic        band_y_ok;
    logic [23:0] phase_step;
    logic [15:0] decay;
    logic [7:0]  gain;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic load_wr;
    logic clr_wr;
    logic band_rd;
    logic band_wr;
    logic phase;
    logic sine;
    logic mul1;
    logic mul2;
    logic clamp;
    logic fetch;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic result_busy;
  } dp_stat_t;

  // sin(pi/2*(2i+1)/(2*depth)) in q1.15 from a q30 taylor series, evaluated at elaboration
  function automatic logic [15:0] sine_entry(input int unsigned idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          s;
    // depth is a power of two, so the divide by twice the depth is a shift
    x = (HALF_PI_Q30 * (64'(idx) * 64'd2 + 64'd1)) >> (SINE_AW + 1);
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    s = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    s = s + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    s = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    s = s + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    s = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    s = s + longint'(term);
    if (s < 0) begin
      s = 0;
    end
    r = (64'(s) + 64'd16384) >> 15;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

// File: design/swarp_cfg.sv
// swarp_cfg: configuration register file and its decoded view
// depends on swarp_pkg
`timescale 1ns / 1ps
`default_nettype none

module swarp_cfg import swarp_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int NUM_BANDS  = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  localparam int LIM_W = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
  localparam int LIM_H = (MAX_HEIGHT < 512) ? MAX_HEIGHT : 512;

  logic [9:0]  frame_width;
  logic [9:0]  frame_height;
  logic [5:0]  band_for_x;
  logic [5:0]  band_for_y;
  logic [23:0] phase_step;
  logic [15:0] decay_factor;
  logic [7:0]  displacement_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= 10'd512;
      frame_height      <= 10'd512;
      band_for_x        <= 6'd2;
      band_for_y        <= 6'd4;
      phase_step        <= 24'd0;
      decay_factor      <= 16'd62259;
      displacement_gain <= 8'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width       <= cfg_data[9:0];
        CFG_FRAME_HEIGHT: frame_height      <= cfg_data[9:0];
        CFG_BAND_FOR_X:   band_for_x        <= cfg_data[5:0];
        CFG_BAND_FOR_Y:   band_for_y        <= cfg_data[5:0];
        CFG_PHASE_STEP:   phase_step        <= cfg_data[23:0];
        CFG_DECAY_FACTOR: decay_factor      <= cfg_data[15:0];
        CFG_DISP_GAIN:    displacement_gain <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // active size saturates to 1 .. min(max, 512)
  always_comb begin
    if (frame_width == 10'd0) begin
      cfg.act_w = 10'd1;
    end else if ({22'd0, frame_width} > 32'(LIM_W)) begin
      cfg.act_w = 10'(LIM_W);
    end else begin
      cfg.act_w = frame_width;
    end
    if (frame_height == 10'd0) begin
      cfg.act_h = 10'd1;
    end else if ({22'd0, frame_height} > 32'(LIM_H)) begin
      cfg.act_h = 10'(LIM_H);
    end else begin
      cfg.act_h = frame_height;
    end
    cfg.band_x     = band_for_x;
    cfg.band_y     = band_for_y;
    cfg.band_x_ok  = {26'd0, band_for_x} < 32'(NUM_BANDS);
    cfg.band_y_ok  = {26'd0, band_for_y} < 32'(NUM_BANDS);
    cfg.phase_step = phase_step;
    cfg.decay      = decay_factor;
    cfg.gain       = displacement_gain;
  end

endmodule

`default_nettype wire

// File: design/swarp_ctrl.sv
// swarp_ctrl: sequencer for band clearing, band updates and render steps
// depends on swarp_pkg
`timescale 1ns / 1ps
`default_nettype none

module swarp_ctrl import swarp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] item_mode,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_BRD   = 11'b000_0000_0100,
    S_BWR   = 11'b000_0000_1000,
    S_PHASE = 11'b000_0001_0000,
    S_SINE  = 11'b000_0010_0000,
    S_MUL1  = 11'b000_0100_0000,
    S_MUL2  = 11'b000_1000_0000,
    S_CLAMP = 11'b001_0000_0000,
    S_FETCH = 11'b010_0000_0000,
    S_EMIT  = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (stat.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (item_mode)
            MODE_BAND:   state_next = S_BRD;
            MODE_RENDER: state_next = S_PHASE;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_BRD:   state_next = S_BWR;
      S_BWR:   state_next = S_IDLE;
      S_PHASE: state_next = S_SINE;
      S_SINE:  state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_CLAMP;
      S_CLAMP: state_next = S_FETCH;
      S_FETCH: state_next = S_EMIT;
      S_EMIT:  if (!stat.result_busy) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd.take    = accept;
    cmd.load_wr = accept && (item_mode == MODE_LOAD);
    cmd.clr_wr  = (state == S_CLEAR);
    cmd.band_rd = (state == S_BRD);
    cmd.band_wr = (state == S_BWR);
    cmd.phase   = (state == S_PHASE);
    cmd.sine    = (state == S_SINE);
    cmd.mul1    = (state == S_MUL1);
    cmd.mul2    = (state == S_MUL2);
    cmd.clamp   = (state == S_CLAMP);
    cmd.fetch   = (state == S_FETCH);
    // result register is free once the waiting item leaves
    cmd.emit    = (state == S_EMIT) && !stat.result_busy;
  end

endmodule

`default_nettype wire

// File: design/swarp_dp.sv
// swarp_dp: frame store, band store, sine rom, multipliers and result register
// depends on swarp_pkg; driven step by step by swarp_ctrl
`timescale 1ns / 1ps
`default_nettype none

module swarp_dp import swarp_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int NUM_BANDS  = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  item_t    item,
  input  cfg_t     cfg,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  localparam int BAND_AW     = $clog2(NUM_BANDS);
  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int FRAME_AW    = $clog2(FRAME_DEPTH);

  // floor(prod / 2^29) added to coord, clamped to 0 .. dim-1
  function automatic logic [8:0] clamp_axis(input logic [8:0] coord,
                                            input logic signed [42:0] prod,
                                            input logic [9:0] dim);
    logic signed [11:0] d;
    logic signed [12:0] pos;
    logic signed [12:0] lim;
    logic [8:0]         res;
    d   = prod[40:29];
    pos = $signed({4'd0, coord}) + $signed({d[11], d});
    lim = $signed({3'd0, dim}) - 13'sd1;
    if (pos < 13'sd0) begin
      res = 9'd0;
    end else if (pos > lim) begin
      res = lim[8:0];
    end else begin
      res = pos[8:0];
    end
    return res;
  endfunction

  // latched item
  logic [8:0]  x_q;
  logic [8:0]  y_q;
  logic [5:0]  band_q;
  logic [15:0] mag_q;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x_q    <= item.x_pos;
      y_q    <= item.y_pos;
      band_q <= item.band_index;
      mag_q  <= item.band_magnitude;
    end
  end

  // band store, cleared by a sweep after reset
  logic [15:0]        band_mem [NUM_BANDS];
  logic [15:0]        band_rdata;
  logic [BAND_AW-1:0] clr_addr;
  logic [BAND_AW-1:0] band_addr_q;
  logic [BAND_AW-1:0] band_addr_x;
  logic [BAND_AW-1:0] band_addr_y;
  logic [BAND_AW-1:0] band_raddr;
  logic [31:0]        band_q_wide;
  logic [31:0]        band_x_wide;
  logic [31:0]        band_y_wide;
  logic               band_q_ok;
  logic [31:0]        held_prod;
  logic [15:0]        held;
  logic [15:0]        band_next;

  assign band_q_wide = {26'd0, band_q};
  assign band_x_wide = {26'd0, cfg.band_x};
  assign band_y_wide = {26'd0, cfg.band_y};
  assign band_addr_q = band_q_wide[BAND_AW-1:0];
  assign band_addr_x = band_x_wide[BAND_AW-1:0];
  assign band_addr_y = band_y_wide[BAND_AW-1:0];
  assign band_q_ok   = band_q_wide < 32'(NUM_BANDS);
  assign stat.clr_last = (clr_addr == BAND_AW'(NUM_BANDS - 1));

  always_comb begin
    if (cmd.band_rd) begin
      band_raddr = band_addr_q;
    end else if (cmd.phase) begin
      band_raddr = band_addr_x;
    end else begin
      band_raddr = band_addr_y;
    end
  end

  // peak hold: decayed level or the new sample, whichever is larger
  assign held_prod = {16'd0, band_rdata} * {16'd0, cfg.decay};
  assign held      = held_prod[31:16];
  assign band_next = (held > mag_q) ? held : mag_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      band_mem[clr_addr] <= 16'd0;
    end else if (cmd.band_wr && band_q_ok) begin
      band_mem[band_addr_q] <= band_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.band_rd || cmd.phase || cmd.sine) begin
      band_rdata <= band_mem[band_raddr];
    end
  end

  // quarter-wave sine rom, two registered read ports
  logic [15:0] sine_rom [SINE_DEPTH];

  for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_sine
    localparam logic [15:0] ENTRY = sine_entry(g);
    assign sine_rom[g] = ENTRY;
  end

  logic [32:0]        px_full;
  logic [32:0]        py_full;
  logic [23:0]        p_x;
  logic [23:0]        p_y;
  logic [SINE_AW-1:0] k_x;
  logic [SINE_AW-1:0] k_y;
  logic [15:0]        sine_mag_x;
  logic [15:0]        sine_mag_y;
  logic               sine_neg_x;
  logic               sine_neg_y;
  logic [15:0]        lev_x;
  logic [15:0]        lev_y;
  logic signed [16:0] sine_x;
  logic signed [16:0] sine_y;
  logic signed [33:0] prod1_x;
  logic signed [33:0] prod1_y;
  logic signed [42:0] prod2_x;
  logic signed [42:0] prod2_y;
  logic [8:0]         sx;
  logic [8:0]         sy;

  assign px_full = {24'd0, x_q} * {9'd0, cfg.phase_step};
  assign py_full = {24'd0, y_q} * {9'd0, cfg.phase_step};

  // odd quadrants walk the table backwards
  assign k_x = p_x[21 -: SINE_AW] ^ {SINE_AW{p_x[22]}};
  assign k_y = p_y[21 -: SINE_AW] ^ {SINE_AW{p_y[22]}};

  assign sine_x = sine_neg_x ? -$signed({1'b0, sine_mag_x}) : $signed({1'b0, sine_mag_x});
  assign sine_y = sine_neg_y ? -$signed({1'b0, sine_mag_y}) : $signed({1'b0, sine_mag_y});
  assign lev_y  = cfg.band_y_ok ? band_rdata : 16'd0;

  always_ff @(posedge clk) begin
    if (cmd.phase) begin
      p_x <= px_full[23:0];
      p_y <= py_full[23:0];
    end
    if (cmd.sine) begin
      sine_mag_x <= sine_rom[k_x];
      sine_mag_y <= sine_rom[k_y];
      sine_neg_x <= p_x[23];
      sine_neg_y <= p_y[23];
      lev_x      <= cfg.band_x_ok ? band_rdata : 16'd0;
    end
    if (cmd.mul1) begin
      prod1_x <= 34'(sine_x) * 34'($signed({1'b0, lev_x}));
      prod1_y <= 34'(sine_y) * 34'($signed({1'b0, lev_y}));
    end
    if (cmd.mul2) begin
      prod2_x <= 43'(prod1_x) * 43'($signed({1'b0, cfg.gain}));
      prod2_y <= 43'(prod1_y) * 43'($signed({1'b0, cfg.gain}));
    end
    if (cmd.clamp) begin
      sx <= clamp_axis(x_q, prod2_x, cfg.act_w);
      sy <= clamp_axis(y_q, prod2_y, cfg.act_h);
    end
  end

  // source frame, row-major with a fixed stride
  logic [23:0]         frame_mem [FRAME_DEPTH];
  logic [23:0]         frame_rdata;
  logic [31:0]         frame_waddr_wide;
  logic [31:0]         frame_raddr_wide;
  logic [FRAME_AW-1:0] frame_waddr;
  logic [FRAME_AW-1:0] frame_raddr;
  logic                load_ok;

  assign frame_waddr_wide = {23'd0, item.y_pos} * 32'(MAX_WIDTH) + {23'd0, item.x_pos};
  assign frame_raddr_wide = {23'd0, sy} * 32'(MAX_WIDTH) + {23'd0, sx};
  assign frame_waddr      = frame_waddr_wide[FRAME_AW-1:0];
  assign frame_raddr      = frame_raddr_wide[FRAME_AW-1:0];
  assign load_ok = ({23'd0, item.x_pos} < 32'(MAX_WIDTH)) &&
                   ({23'd0, item.y_pos} < 32'(MAX_HEIGHT));

  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_ok) begin
      frame_mem[frame_waddr] <= item.pixel_color;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      frame_rdata <= frame_mem[frame_raddr];
    end
  end

  // result register
  assign stat.result_busy = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.warped_color <= frame_rdata;
      result.source_x     <= sx;
      result.source_y     <= sy;
    end
  end

endmodule

`default_nettype wire

// File: design/spectrum_driven_sine_warp_core.sv
// spectrum_driven_sine_warp_core: top level of the spectrum driven sine warp
// depends on swarp_pkg, swarp_cfg, swarp_ctrl, swarp_dp
//
//  channel   handshake                payload              direction
//  item      item_valid / item_stall  item (item_t)        into the block
//  result    result_valid / result_stall  result (result_t)  out of the block
//  cfg       cfg_valid / cfg_ready    cfg_index, cfg_data  into the block
//
// a load item is written from idle, a band item does a band store read, then decay and write back
// a render item steps through phase multiply, sine rom and level reads, two
// multiplies, clamp, frame read, then the result register
// after reset the band store is swept to zero with item_stall high
// a render waits in its last step while an earlier result is still stalled
`timescale 1ns / 1ps
`default_nettype none

module spectrum_driven_sine_warp_core import swarp_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int NUM_BANDS  = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  swarp_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .NUM_BANDS (NUM_BANDS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  swarp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item_mode (item.mode),
    .stat      (stat),
    .cmd       (cmd)
  );

  swarp_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .NUM_BANDS (NUM_BANDS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cfg         (cfg),
    .cmd         (cmd),
    .stat        (stat),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

`default_nettype wire

// File: tb/tb_spectrum_driven_sine_warp_core.sv
// tb_spectrum_driven_sine_warp_core: self-checking regression for the sine warp core
// a scoreboard class predicts frame loads, band peak-hold and render results
// depends on swarp_pkg and spectrum_driven_sine_warp_core
`timescale 1ns / 1ps

module tb_spectrum_driven_sine_warp_core;
  import swarp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS = 220;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  class warp_scoreboard;
    logic [15:0] quarter_sine [SINE_DEPTH];
    logic [23:0] frame_mem [int unsigned];
    logic [15:0] band_level [64];
    logic [9:0]  width_reg;
    logic [9:0]  height_reg;
    logic [5:0]  x_band;
    logic [5:0]  y_band;
    logic [23:0] phase_inc;
    logic [15:0] decay;
    logic [7:0]  gain;
    result_t     pending [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned loads;
    int unsigned bands;
    int unsigned renders;
    int unsigned ignored;

    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned r;
      longint          s;
      // q1.15 quarter-wave table from a q30 taylor series, six terms past x
      for (int i = 0; i < SINE_DEPTH; i++) begin
        x = (QUARTER_TURN_Q30 * (64'(i) * 2 + 1)) / (64'(SINE_DEPTH) * 2);
        x2 = (x * x) >> 30;
        term = x;
        s = longint'(x);
        for (int k = 1; k <= 6; k++) begin
          term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            s -= longint'(term);
          end else begin
            s += longint'(term);
          end
        end
        if (s < 0) begin
          s = 0;
        end
        r = (64'(s) + 64'd16384) >> 15;
        if (r > 64'd32768) begin
          r = 64'd32768;
        end
        quarter_sine[i] = r[15:0];
      end
      foreach (band_level[b]) begin
        band_level[b] = '0;
      end
      width_reg = 10'd512;
      height_reg = 10'd512;
      x_band = 6'd2;
      y_band = 6'd4;
      phase_inc = '0;
      decay = 16'd62259;
      gain = 8'd100;
    endfunction

    function int unsigned active(input logic [9:0] v);
      if (v == 0) begin
        return 1;
      end
      if (v > 10'd512) begin
        return 512;
      end
      return 32'(v);
    endfunction

    function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg = data[9:0];
        CFG_FRAME_HEIGHT: height_reg = data[9:0];
        CFG_BAND_FOR_X:   x_band = data[5:0];
        CFG_BAND_FOR_Y:   y_band = data[5:0];
        CFG_PHASE_STEP:   phase_inc = data[23:0];
        CFG_DECAY_FACTOR: decay = data[15:0];
        CFG_DISP_GAIN:    gain = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [8:0] warp_axis(input logic [8:0] c, input logic [5:0] band,
                                   input int unsigned dim);
      longint unsigned t;
      logic [23:0]     p;
      logic [9:0]      k;
      longint          sv;
      longint          lv;
      longint          g;
      longint          pos;
      t = 64'(c) * 64'(phase_inc);
      p = t[23:0];
      k = p[21:12];
      // odd quadrants run the table backwards, the second half-turn negates
      if (p[22]) begin
        k = 10'(SINE_DEPTH - 1) - k;
      end
      sv = longint'(quarter_sine[k]);
      if (p[23]) begin
        sv = -sv;
      end
      lv = longint'(band_level[band]);
      g = longint'(gain);
      // arithmetic shift floors toward minus infinity
      pos = longint'(c) + ((sv * lv * g) >>> 29);
      if (pos < 0) begin
        pos = 0;
      end
      if (pos > longint'(dim) - 1) begin
        pos = longint'(dim) - 1;
      end
      return pos[8:0];
    endfunction

    function void source_of(input logic [8:0] x, input logic [8:0] y,
                            output logic [8:0] sx, output logic [8:0] sy);
      sx = warp_axis(x, x_band, active(width_reg));
      sy = warp_axis(y, y_band, active(height_reg));
    endfunction

    function bit written(input logic [8:0] sx, input logic [8:0] sy);
      int unsigned addr;
      addr = 32'({sy, sx});
      return frame_mem.exists(addr);
    endfunction

    function void note_item(input item_t it);
      logic [31:0]  held;
      result_t      exp;
      int unsigned  addr;
      case (it.mode)
        MODE_LOAD: begin
          addr = 32'({it.y_pos, it.x_pos});
          frame_mem[addr] = it.pixel_color;
          loads++;
        end
        MODE_BAND: begin
          held = (32'(band_level[it.band_index]) * 32'(decay)) >> 16;
          band_level[it.band_index] = (held > 32'(it.band_magnitude)) ? held[15:0]
                                                                       : it.band_magnitude;
          bands++;
        end
        MODE_RENDER: begin
          source_of(it.x_pos, it.y_pos, exp.source_x, exp.source_y);
          addr = 32'({exp.source_y, exp.source_x});
          exp.warped_color = frame_mem.exists(addr) ? frame_mem[addr] : 24'd0;
          pending.push_back(exp);
          renders++;
        end
        default: ignored++;
      endcase
    endfunction

    function void check_result(input result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: color %h x %0d y %0d",
                   got.warped_color, got.source_x, got.source_y);
        end
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.warped_color !== exp.warped_color || got.source_x !== exp.source_x ||
          got.source_y !== exp.source_y) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch: expected color %h x %0d y %0d, got color %h x %0d y %0d",
                   checked, exp.warped_color, exp.source_x, exp.source_y,
                   got.warped_color, got.source_x, got.source_y);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  item_t                  item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  warp_scoreboard sb = new();
  bit             calm = 1'b0;
  int             hold_left = 0;
  int unsigned    settings = 0;
  int unsigned    sent = 0;

  spectrum_driven_sine_warp_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(result);
    end
  end

  // result side: random stalls, or a counted hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_stall = 1'b1;
        hold_left--;
      end else if (calm) begin
        result_stall = 1'b0;
      end else begin
        result_stall = ($urandom_range(99) < 33);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending.size());
    $display("spectrum_driven_sine_warp_core regression: fail");
    $finish;
  end

  function automatic item_t random_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[65:0];
  endfunction

  task automatic push_item(input item_t it);
    while (!calm && $urandom_range(99) < 33) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item = it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_load(input logic [8:0] x, input logic [8:0] y, input logic [23:0] color);
    item_t it;
    it = random_item();
    it.mode = MODE_LOAD;
    it.x_pos = x;
    it.y_pos = y;
    it.pixel_color = color;
    push_item(it);
  endtask

  task automatic send_band(input logic [5:0] b, input logic [15:0] mag);
    item_t it;
    it = random_item();
    it.mode = MODE_BAND;
    it.band_index = b;
    it.band_magnitude = mag;
    push_item(it);
  endtask

  // a render whose source pixel is still unwritten gets a load for it first
  task automatic send_render(input logic [8:0] x, input logic [8:0] y);
    item_t      it;
    logic [8:0] sx;
    logic [8:0] sy;
    sb.source_of(x, y, sx, sy);
    if (!sb.written(sx, sy)) begin
      send_load(sx, sy, 24'($urandom));
    end
    it = random_item();
    it.mode = MODE_RENDER;
    it.x_pos = x;
    it.y_pos = y;
    push_item(it);
  endtask

  task automatic send_spare();
    item_t it;
    it = random_item();
    it.mode = MODE_SPARE;
    push_item(it);
  endtask

  task automatic drain();
    item_valid = 1'b0;
    while (sb.pending.size() != 0) begin
      @(negedge clk);
    end
    // band and load items give no result and may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(input logic [23:0] w, input logic [23:0] h,
                               input logic [23:0] bx, input logic [23:0] by,
                               input logic [23:0] inc, input logic [23:0] dk,
                               input logic [23:0] g);
    drain();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_BAND_FOR_X, bx);
    write_reg(CFG_BAND_FOR_Y, by);
    write_reg(CFG_PHASE_STEP, inc);
    write_reg(CFG_DECAY_FACTOR, dk);
    write_reg(CFG_DISP_GAIN, g);
    settings++;
  endtask

  // count covers every item sent, the extra loads ahead of renders included
  task automatic run_random(input int count, input bit sync_midway);
    int unsigned start;
    int unsigned r;
    int unsigned aw;
    int unsigned ah;
    logic [15:0] mag;
    bit          synced;
    start = sent;
    synced = 1'b0;
    aw = sb.active(sb.width_reg);
    ah = sb.active(sb.height_reg);
    while (int'(sent - start) < count) begin
      if (sync_midway && !synced && int'(sent - start) >= count / 2) begin
        // sender waits for every outstanding result before going on
        item_valid = 1'b0;
        while (sb.pending.size() != 0) begin
          @(negedge clk);
        end
        synced = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 5) begin
        send_spare();
      end else if (r < 25) begin
        if ($urandom_range(3) != 0) begin
          send_load(9'($urandom_range(aw - 1, 0)), 9'($urandom_range(ah - 1, 0)),
                    24'($urandom));
        end else begin
          send_load(9'($urandom), 9'($urandom), 24'($urandom));
        end
      end else if (r < 50) begin
        case ($urandom_range(9))
          0:       mag = 16'h0000;
          1:       mag = 16'hFFFF;
          default: mag = 16'($urandom);
        endcase
        case ($urandom_range(9))
          0, 1, 2, 3: send_band(sb.x_band, mag);
          4, 5, 6:    send_band(sb.y_band, mag);
          default:    send_band(6'($urandom), mag);
        endcase
      end else begin
        if ($urandom_range(9) < 6) begin
          send_render(9'($urandom), 9'($urandom));
        end else begin
          send_render(9'($urandom_range(aw - 1, 0)), 9'($urandom_range(ah - 1, 0)));
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: quarter-turn phase with full gain drives displacement to both clamps
    apply_setting(24'd512, 24'd512, 24'd0, 24'd63, 24'h400000, 24'hFFFF, 24'd255);
    send_load(9'd0, 9'd0, 24'h000000);
    send_load(9'd511, 9'd511, 24'hFFFFFF);
    send_load(9'd511, 9'd0, 24'hA5A5A5);
    send_load(9'd0, 9'd511, 24'h5A5A5A);
    send_render(9'd0, 9'd0);
    send_band(6'd0, 16'hFFFF);
    send_band(6'd63, 16'hFFFF);
    send_render(9'd1, 9'd1);
    send_render(9'd3, 9'd3);
    send_render(9'd511, 9'd511);
    send_render(9'd2, 9'd511);
    send_band(6'd0, 16'h0000);
    send_band(6'd63, 16'h0001);
    send_render(9'd511, 9'd2);
    send_render(9'd1, 9'd3);
    send_spare();

    // small frame, receiver holds off long enough to back up the input
    apply_setting(24'd16, 24'd16, 24'($urandom_range(63)), 24'($urandom_range(63)),
                  24'($urandom), 24'd62259, 24'd100);
    hold_left = HOLD_OFF_CYCLES;
    run_random(PHASE_ITEMS, 1'b0);

    // zero size saturates to one pixel, zero decay factor so no peak hold, widest phase step
    apply_setting(24'd0, 24'd0, 24'd0, 24'd63, 24'hFFFFFF, 24'd0, 24'd255);
    run_random(PHASE_ITEMS, 1'b1);

    // full frame with slow phase, loads follow the renders around
    apply_setting(24'd512, 24'd512, 24'd2, 24'd4, 24'($urandom_range(24'h3FFF, 1)),
                  24'hFFFF, 24'd255);
    run_random(PHASE_ITEMS, 1'b0);

    // oversize registers, zero gain, both sides streaming with no gaps
    calm = 1'b1;
    apply_setting(24'hFFFFFF, 24'h3FF, 24'd63, 24'd0, 24'($urandom), 24'(16'($urandom)),
                  24'd0);
    run_random(PHASE_ITEMS, 1'b0);
    calm = 1'b0;

    apply_setting(24'd1, 24'd512, 24'($urandom_range(63)), 24'($urandom_range(63)),
                  24'($urandom), 24'(16'($urandom)), 24'(8'($urandom)));
    run_random(PHASE_ITEMS, 1'b0);

    apply_setting(24'($urandom_range(64, 1)), 24'($urandom_range(64, 1)),
                  24'($urandom_range(63)), 24'($urandom_range(63)),
                  24'($urandom_range(24'h3FFFF)), 24'(16'($urandom)), 24'(8'($urandom)));
    run_random(PHASE_ITEMS, 1'b0);

    apply_setting(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), 24'($urandom), 24'($urandom));
    run_random(PHASE_ITEMS, 1'b0);

    drain();
    $display("covered %0d loads, %0d band samples, %0d renders, %0d ignored items",
             sb.loads, sb.bands, sb.renders, sb.ignored);
    $display("%0d results checked over %0d register settings, %0d mismatches",
             sb.checked, settings, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("spectrum_driven_sine_warp_core regression: pass");
    end else begin
      $display("spectrum_driven_sine_warp_core regression: fail");
    end
    $finish;
  end

endmodule
